// File: rtl/core/cait_pkg.sv
// shared types and constants for the child ipv6 address table
`default_nettype none

package cait_pkg;

  // default number of table slots
  localparam int unsigned NumSlotsDef = 4;

  // apb address width: one 64-bit register at byte address 0
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 64;

  // register index within the config space
  localparam logic RegMeshLocalPrefix = 1'b0;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CLASS = 2'd1,
    S_SCAN  = 2'd2,
    S_EMIT  = 2'd3
  } state_e;

  // result of the shared compare unit
  typedef struct packed {
    logic eq_hi;
    logic eq_lo;
    logic a_zero;
  } cmp_res_t;

  // storage update commands from the sequencer
  typedef struct packed {
    logic tab_wr;
    logic tab_shift;
    logic clr_all;
    logic iid_set;
    logic iid_clr;
  } store_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/cait_cmp.sv
// shared 128-bit compare unit: half-word equality and zero test
`default_nettype none

module cait_cmp (
  input  logic [63:0]        a_hi_i,
  input  logic [63:0]        a_lo_i,
  input  logic [63:0]        b_hi_i,
  input  logic [63:0]        b_lo_i,
  output cait_pkg::cmp_res_t res_o
);

  assign res_o.eq_hi  = (a_hi_i == b_hi_i);
  assign res_o.eq_lo  = (a_lo_i == b_lo_i);
  assign res_o.a_zero = (a_hi_i == 64'd0) && (a_lo_i == 64'd0);

endmodule

`default_nettype wire

// File: rtl/core/cait_store.sv
// address table slots and mesh-local identifier slot
`default_nettype none

module cait_store #(
  parameter int unsigned NumSlots = cait_pkg::NumSlotsDef,
  parameter int unsigned IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cait_pkg::store_ctrl_t  ctrl_i,
  input  logic [IdxW-1:0]        idx_i,
  input  logic [63:0]            key_hi_i,
  input  logic [63:0]            key_lo_i,
  output logic [63:0]            rd_hi_o,
  output logic [63:0]            rd_lo_o,
  output logic [63:0]            iid_o
);

  logic [63:0] hi_q [NumSlots];
  logic [63:0] lo_q [NumSlots];
  logic [63:0] iid_q;

  assign rd_hi_o = hi_q[idx_i];
  assign rd_lo_o = lo_q[idx_i];
  assign iid_o   = iid_q;

  for (genvar i = 0; i < NumSlots; i++) begin : g_slot
    logic [63:0] nxt_hi;
    logic [63:0] nxt_lo;
    logic        at_or_above;

    assign at_or_above = (IdxW'(i) >= idx_i);

    // upper neighbor moves down on remove, last slot empties
    if (i == NumSlots - 1) begin : g_last
      assign nxt_hi = 64'd0;
      assign nxt_lo = 64'd0;
    end else begin : g_mid
      assign nxt_hi = hi_q[i+1];
      assign nxt_lo = lo_q[i+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hi_q[i] <= 64'd0;
        lo_q[i] <= 64'd0;
      end else if (ctrl_i.clr_all) begin
        hi_q[i] <= 64'd0;
        lo_q[i] <= 64'd0;
      end else if (ctrl_i.tab_wr && (idx_i == IdxW'(i))) begin
        hi_q[i] <= key_hi_i;
        lo_q[i] <= key_lo_i;
      end else if (ctrl_i.tab_shift && at_or_above) begin
        hi_q[i] <= nxt_hi;
        lo_q[i] <= nxt_lo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iid_q <= 64'd0;
    end else if (ctrl_i.clr_all || ctrl_i.iid_clr) begin
      iid_q <= 64'd0;
    end else if (ctrl_i.iid_set) begin
      iid_q <= key_lo_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cait_seq.sv
// operation sequencer: classify, scan slots, update storage, hold result
`default_nettype none

module cait_seq #(
  parameter int unsigned NumSlots = cait_pkg::NumSlotsDef,
  parameter int unsigned IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic [63:0]            addr_high_i,
  input  logic [63:0]            addr_low_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic                   present_o,
  input  logic [63:0]            prefix_i,
  input  logic [63:0]            rd_hi_i,
  input  logic [63:0]            rd_lo_i,
  input  logic [63:0]            iid_i,
  output cait_pkg::store_ctrl_t  ctrl_o,
  output logic [IdxW-1:0]        idx_o,
  output logic [63:0]            key_hi_o,
  output logic [63:0]            key_lo_o
);

  cait_pkg::state_e  state_q, state_d;
  cait_pkg::func_e   func_q, func_d;
  logic [63:0]       key_hi_q, key_hi_d;
  logic [63:0]       key_lo_q, key_lo_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  cait_pkg::status_e res_status_q, res_status_d;
  logic              res_present_q, res_present_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q, status_d;
  logic              present_q, present_d;

  logic [63:0]        cmp_a_hi, cmp_a_lo, cmp_b_hi, cmp_b_lo;
  cait_pkg::cmp_res_t cmp;
  logic               hit, last;

  // scan compares the selected slot with the key, classify compares
  // the key with prefix and identifier
  always_comb begin
    if (state_q == cait_pkg::S_SCAN) begin
      cmp_a_hi = rd_hi_i;
      cmp_a_lo = rd_lo_i;
      cmp_b_hi = key_hi_q;
      cmp_b_lo = key_lo_q;
    end else begin
      cmp_a_hi = key_hi_q;
      cmp_a_lo = key_lo_q;
      cmp_b_hi = prefix_i;
      cmp_b_lo = iid_i;
    end
  end

  cait_cmp u_cmp (
    .a_hi_i (cmp_a_hi),
    .a_lo_i (cmp_a_lo),
    .b_hi_i (cmp_b_hi),
    .b_lo_i (cmp_b_lo),
    .res_o  (cmp)
  );

  assign hit  = cmp.eq_hi && cmp.eq_lo;
  assign last = (idx_q == IdxW'(NumSlots - 1));

  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    key_hi_d      = key_hi_q;
    key_lo_d      = key_lo_q;
    idx_d         = idx_q;
    res_status_d  = res_status_q;
    res_present_d = res_present_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    present_d     = present_q;
    ctrl_o        = '0;
    in_ready_o    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cait_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d        = cait_pkg::func_e'(func_i);
          key_hi_d      = addr_high_i;
          key_lo_d      = addr_low_i;
          res_status_d  = cait_pkg::ST_OK;
          res_present_d = 1'b0;
          state_d       = cait_pkg::S_CLASS;
        end
      end

      cait_pkg::S_CLASS: begin
        state_d = cait_pkg::S_EMIT;
        if (func_q == cait_pkg::FUNC_CLEAR) begin
          ctrl_o.clr_all = 1'b1;
        end else if (cmp.a_zero) begin
          res_status_d = cait_pkg::ST_INVALID;
        end else if (cmp.eq_hi) begin
          // mesh-local: identifier slot only
          case (func_q)
            cait_pkg::FUNC_ADD: begin
              if (iid_i != 64'd0) begin
                res_status_d = cait_pkg::ST_ALREADY;
              end else begin
                ctrl_o.iid_set = 1'b1;
              end
            end
            cait_pkg::FUNC_REMOVE: begin
              if (cmp.eq_lo) begin
                ctrl_o.iid_clr = 1'b1;
              end else begin
                res_status_d = cait_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              res_present_d = cmp.eq_lo;
            end
          endcase
        end else begin
          idx_d   = '0;
          state_d = cait_pkg::S_SCAN;
        end
      end

      cait_pkg::S_SCAN: begin
        case (func_q)
          cait_pkg::FUNC_ADD: begin
            if (cmp.a_zero) begin
              ctrl_o.tab_wr = 1'b1;
              state_d       = cait_pkg::S_EMIT;
            end else if (hit) begin
              res_status_d = cait_pkg::ST_ALREADY;
              state_d      = cait_pkg::S_EMIT;
            end else if (last) begin
              res_status_d = cait_pkg::ST_FULL;
              state_d      = cait_pkg::S_EMIT;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          cait_pkg::FUNC_REMOVE: begin
            if (hit) begin
              ctrl_o.tab_shift = 1'b1;
              state_d          = cait_pkg::S_EMIT;
            end else if (cmp.a_zero || last) begin
              res_status_d = cait_pkg::ST_NOT_FOUND;
              state_d      = cait_pkg::S_EMIT;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          default: begin
            if (hit) begin
              res_present_d = 1'b1;
              state_d       = cait_pkg::S_EMIT;
            end else if (cmp.a_zero || last) begin
              state_d = cait_pkg::S_EMIT;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
        endcase
      end

      cait_pkg::S_EMIT: begin
        // load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          present_d   = res_present_q;
          state_d     = cait_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cait_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cait_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q        <= func_d;
    key_hi_q      <= key_hi_d;
    key_lo_q      <= key_lo_d;
    idx_q         <= idx_d;
    res_status_q  <= res_status_d;
    res_present_q <= res_present_d;
    status_q      <= status_d;
    present_q     <= present_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign present_o   = present_q;
  assign idx_o       = idx_q;
  assign key_hi_o    = key_hi_q;
  assign key_lo_o    = key_lo_q;

endmodule

`default_nettype wire

// File: rtl/core/child_ipv6_address_table_top.sv
// top level of the child ipv6 address table
`default_nettype none

// Holds the IPv6 addresses registered by one child: a gap-free table of
// NumSlots 128-bit addresses filled from slot 0, plus one 64-bit slot for the
// mesh-local interface identifier. Each item carries an operation (add,
// remove, query, clear) and an address; each item gives exactly one result
// (status, present). An address whose upper half equals mesh_local_prefix
// (APB register at byte address 0) goes to the identifier slot, any other to
// the table; the all-zero address is rejected. A small sequencer drives one
// shared 128-bit compare unit: it first classifies the item against prefix
// and identifier, then scans the table slot by slot in order until an empty
// slot, a match or the last slot. Remove closes the gap in the same cycle as
// the match by moving every later slot down. The result sits in an output
// register, so a result waiting downstream does not stop the next item from
// being taken; it only holds that item before its result is loaded. All
// storage is cleared by reset and by the clear operation, with no clearing
// pass. Configuration writes are expected only while the block is idle.
module child_ipv6_address_table_top #(
  parameter int unsigned NumSlots = cait_pkg::NumSlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item in
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [63:0]                 addr_high_i,
  input  logic [63:0]                 addr_low_i,
  // result out
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic                        present_o,
  // apb config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cait_pkg::PaddrW-1:0] paddr,
  input  logic [cait_pkg::PdataW-1:0] pwdata,
  output logic [cait_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // config register
  logic [63:0] prefix_q;
  logic        reg_sel;

  // register index is the 8-byte word address
  assign reg_sel = (paddr[cait_pkg::PaddrW-1] == cait_pkg::RegMeshLocalPrefix);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? prefix_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 64'd0;
    end else if (psel && penable && pwrite && reg_sel) begin
      prefix_q <= pwdata;
    end
  end

  // sequencer to storage
  cait_pkg::store_ctrl_t ctrl;
  logic [IdxW-1:0]       idx;
  logic [63:0]           key_hi, key_lo;
  logic [63:0]           rd_hi, rd_lo, iid;

  cait_seq #(
    .NumSlots (NumSlots),
    .IdxW     (IdxW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .addr_high_i (addr_high_i),
    .addr_low_i  (addr_low_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .present_o   (present_o),
    .prefix_i    (prefix_q),
    .rd_hi_i     (rd_hi),
    .rd_lo_i     (rd_lo),
    .iid_i       (iid),
    .ctrl_o      (ctrl),
    .idx_o       (idx),
    .key_hi_o    (key_hi),
    .key_lo_o    (key_lo)
  );

  // slot table and identifier slot
  cait_store #(
    .NumSlots (NumSlots),
    .IdxW     (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .idx_i    (idx),
    .key_hi_i (key_hi),
    .key_lo_i (key_lo),
    .rd_hi_o  (rd_hi),
    .rd_lo_o  (rd_lo),
    .iid_o    (iid)
  );

endmodule

`default_nettype wire

// File: rtl/core/cait_checker.sv
// port-level checks for the child ipv6 address table, bound to the top level
`default_nettype none

module cait_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] func_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic       present_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(present_o))
    else $error("result changed while stalled");

  // present only comes with ok status
  a_present_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && present_o |-> status_o == cait_pkg::ST_OK)
    else $error("present set with non-ok status");

  // status is a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == cait_pkg::ST_OK || status_o == cait_pkg::ST_INVALID ||
                    status_o == cait_pkg::ST_ALREADY || status_o == cait_pkg::ST_FULL ||
                    status_o == cait_pkg::ST_NOT_FOUND)
    else $error("undefined status code");

  // busy after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an item was taken");

  // clear never reports an error; checked when the output is free as the item is taken
  a_clear_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == cait_pkg::FUNC_CLEAR &&
      (!out_valid_o || out_ready_i) |=> ##2
      out_valid_o && status_o == cait_pkg::ST_OK && !present_o)
    else $error("clear item gave a bad result");

endmodule

bind child_ipv6_address_table_top cait_checker u_cait_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .present_o   (present_o)
);

`default_nettype wire
